### sv/mii_phy_register_file_top_defines.svh
// Assertion macros for the PHY management register file.
`ifndef MII_PHY_REGISTER_FILE_TOP_DEFINES_SVH
`define MII_PHY_REGISTER_FILE_TOP_DEFINES_SVH
`ifndef SYNTH
`define MPRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mii phy register file: immediate check failed");
`define MPRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mii phy register file: next-cycle check failed");
`else
`define MPRF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MPRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/mii_prf_pkg.sv
// Types, constants and reset values of the PHY management register file.
package mii_prf_pkg;

	typedef logic [15:0] mreg_t;
	typedef logic [4:0]  maddr_t;

	localparam int unsigned NumRegs = 32;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic CFG_IDX_ENABLE = 1'b0;

	localparam int unsigned CTRL_RESET_BIT   = 15;
	localparam int unsigned CTRL_AUTONEG_BIT = 12;
	localparam int unsigned CTRL_RENEG_BIT   = 9;

	localparam maddr_t ADDR_CTRL = 5'd0;
	localparam maddr_t ADDR_RO_LO = 5'd1;
	localparam maddr_t ADDR_RO_HI = 5'd3;

	localparam mreg_t DEF_CTRL   = 16'h3100;
	localparam mreg_t DEF_STATUS = 16'h782D;
	localparam mreg_t DEF_ANAR   = 16'h01E1;
	localparam mreg_t DEF_ANLPAR = 16'h85E1;

	// value an entry holds after reset or a defaults reload
	function automatic mreg_t reset_value(input maddr_t addr);
		mreg_t v;
		case (addr)
			5'd0: v = DEF_CTRL;
			5'd1: v = DEF_STATUS;
			5'd4: v = DEF_ANAR;
			5'd5: v = DEF_ANLPAR;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### sv/mii_phy_register_file_top.sv
// PHY management register file: 32 x 16-bit registers in one synchronous memory.
//
//  port group  | direction | handshake
//  ------------+-----------+-------------------------------------------
//  access item | in        | start, accepted when start && !busy
//  result item | out       | done strobe, one cycle, no back-pressure
//  config      | in/out    | APB write when psel && penable && pwrite
//
// For each item, the accept edge issues the memory read, the next cycle does
// the modify and write-back and registers the result, which shows on
// read_data together with done. busy is high for that one cycle only, so a
// new item may be taken while done is shown.
// A valid bit per entry, cleared by arst_n, makes never-written entries read
// their reset value; a defaults reload clears the bits of registers 1 to 5.
`include "mii_phy_register_file_top_defines.svh"
module mii_phy_register_file_top
	import mii_prf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [4:0]  reg_addr,
	input  logic [15:0] write_data,
	output logic        done,
	output logic [15:0] read_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mreg_t              mem [NumRegs];
	logic [NumRegs-1:0] valid_q;
	logic               enabled_q;

	logic   busy_q;
	logic   op_s1;
	maddr_t addr_s1;
	mreg_t  wdata_s1;
	mreg_t  rd_s1;
	logic   vld_s1;

	logic  done_q;
	mreg_t read_data_q;

	logic  accept;
	logic  cfg_wr;
	mreg_t reg_val;
	mreg_t wval;
	logic  autoneg_now;
	logic  reload;
	logic  read_only;
	logic  wr_en;

	assign accept = start && !busy_q;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_ENABLE) ? {31'd0, enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == CFG_IDX_ENABLE) begin
			enabled_q <= pwdata[0];
		end
	end

	// memory: read at accept, write-back in the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[reg_addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			addr_s1  <= reg_addr;
			wdata_s1 <= write_data;
			vld_s1   <= valid_q[reg_addr];
		end
	end

	assign reg_val = vld_s1 ? rd_s1 : reset_value(addr_s1);

	// reset bit reloads first, so the auto-neg check then sees the default
	assign autoneg_now = wdata_s1[CTRL_RESET_BIT] ? DEF_CTRL[CTRL_AUTONEG_BIT]
	                                               : reg_val[CTRL_AUTONEG_BIT];
	assign reload = wdata_s1[CTRL_RESET_BIT] ||
	                (wdata_s1[CTRL_RENEG_BIT] && autoneg_now);

	always_comb begin
		wval = wdata_s1;
		if (addr_s1 == ADDR_CTRL) begin
			wval[CTRL_RESET_BIT] = 1'b0;
			wval[CTRL_RENEG_BIT] = 1'b0;
		end
	end

	assign read_only = (addr_s1 >= ADDR_RO_LO) && (addr_s1 <= ADDR_RO_HI);
	assign wr_en     = busy_q && enabled_q && (op_s1 == OP_WRITE) && !read_only;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			// reload: registers 1 to 5 fall back to defaults, 0 takes the write
			if (addr_s1 == ADDR_CTRL && reload) begin
				valid_q[5:0] <= 6'b000001;
			end else begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			read_data_q <= (enabled_q && op_s1 == OP_READ) ? reg_val : '0;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign read_data = read_data_q;

	`MPRF_ASSERT_NEXT(a_one_cycle_work, clk, arst_n, busy_q, !busy_q && done_q)
	`MPRF_ASSERT_NEXT(a_write_gives_zero, clk, arst_n, busy_q && op_s1 == OP_WRITE,
		read_data == 16'd0)
	`MPRF_ASSERT_NOW(a_ro_never_written, clk, arst_n, 1'b1, valid_q[3:1] == 3'd0)
	`MPRF_ASSERT_NEXT(a_disabled_no_write, clk, arst_n, busy_q && !enabled_q,
		$stable(valid_q))

endmodule

### test/tb_mii_phy_register_file_top.sv
// Testbench for the PHY management register file: directed table, then random accesses.
module tb_mii_phy_register_file_top
	import mii_prf_pkg::*;
;

	localparam int IdlePct    = 23;
	localparam int StallLimit = 2000;
	localparam int NumDir     = 29;

	typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_t;

	// data holds the write value, or the enable bit for a config row
	typedef struct packed {
		row_kind_t kind;
		logic      op;
		maddr_t    addr;
		mreg_t     data;
		logic      typed;
		mreg_t     want;
	} dir_row_t;

	localparam dir_row_t DirTab [NumDir] = '{
		'{ROW_ACCESS, OP_READ,  ADDR_CTRL, 16'h0000, 1'b1, 16'h0000},
		'{ROW_ACCESS, OP_WRITE, 5'd4,      16'hFFFF, 1'b1, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd4,      16'h0000, 1'b1, 16'h0000},
		'{ROW_CFG,    OP_WRITE, ADDR_CTRL, 16'h0001, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  ADDR_CTRL, 16'h0000, 1'b1, 16'h3100},
		'{ROW_ACCESS, OP_READ,  5'd1,      16'h0000, 1'b1, 16'h782D},
		'{ROW_ACCESS, OP_READ,  5'd4,      16'h0000, 1'b1, 16'h01E1},
		'{ROW_ACCESS, OP_READ,  5'd5,      16'h0000, 1'b1, 16'h85E1},
		'{ROW_ACCESS, OP_WRITE, 5'd31,     16'hFFFF, 1'b1, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd31,     16'h0000, 1'b1, 16'hFFFF},
		'{ROW_ACCESS, OP_WRITE, 5'd1,      16'h0000, 1'b1, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd1,      16'h0000, 1'b1, 16'h782D},
		'{ROW_ACCESS, OP_WRITE, 5'd4,      16'h0000, 1'b1, 16'h0000},
		// loopback and collision test, autoneg off
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'h4080, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  ADDR_CTRL, 16'h0000, 1'b0, 16'h0000},
		// renegotiate with autoneg off: no reload
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'h0200, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd4,      16'h0000, 1'b0, 16'h0000},
		// renegotiate with autoneg on: reload
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'h1000, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'h1200, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd4,      16'h0000, 1'b0, 16'h0000},
		// soft reset bit
		'{ROW_ACCESS, OP_WRITE, 5'd5,      16'h0000, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'h8000, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd5,      16'h0000, 1'b1, 16'h85E1},
		'{ROW_ACCESS, OP_WRITE, ADDR_CTRL, 16'hFFFF, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  ADDR_CTRL, 16'h0000, 1'b0, 16'h0000},
		'{ROW_CFG,    OP_WRITE, ADDR_CTRL, 16'h0000, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  ADDR_CTRL, 16'h0000, 1'b1, 16'h0000},
		'{ROW_CFG,    OP_WRITE, ADDR_CTRL, 16'h0001, 1'b0, 16'h0000},
		'{ROW_ACCESS, OP_READ,  5'd2,      16'h0000, 1'b1, 16'h0000}
	};

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        operation  = OP_READ;
	logic [4:0]  reg_addr   = '0;
	logic [15:0] write_data = '0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic        busy;
	logic        done;
	logic [15:0] read_data;
	logic [31:0] prdata;
	logic        pready;

	mreg_t       phy_regs [NumRegs];
	logic        phy_en;
	mreg_t       rd_data_q [$];
	int unsigned n_errors     = 0;
	int unsigned stall_cycles = 0;
	bit          idling_on    = 1'b1;

	mii_phy_register_file_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void load_phy_defaults();
		for (int i = 0; i < 6; i++)
			phy_regs[i] = '0;
		phy_regs[0] = DEF_CTRL;
		phy_regs[1] = DEF_STATUS;
		phy_regs[4] = DEF_ANAR;
		phy_regs[5] = DEF_ANLPAR;
	endfunction

	// updates the register image and returns the read data the access gives
	function automatic mreg_t phy_reg_access(logic op, maddr_t addr, mreg_t wdata);
		mreg_t v;
		v = wdata;
		if (!phy_en)
			return '0;
		if (op == OP_READ)
			return phy_regs[addr];
		if (addr == ADDR_CTRL) begin
			if (v[CTRL_RESET_BIT]) begin
				v[CTRL_RESET_BIT] = 1'b0;
				load_phy_defaults();
			end
			if (v[CTRL_RENEG_BIT]) begin
				v[CTRL_RENEG_BIT] = 1'b0;
				// looks at register 0 after any reload by the reset bit
				if (phy_regs[ADDR_CTRL][CTRL_AUTONEG_BIT])
					load_phy_defaults();
			end
			phy_regs[ADDR_CTRL] = v;
		end else if (addr > ADDR_RO_HI) begin
			phy_regs[addr] = v;
		end
		return '0;
	endfunction

	// returns at the accept edge; the caller drives start in that same step
	task automatic send_access(input logic op, input maddr_t addr, input mreg_t wdata,
			input logic typed, input mreg_t typed_rd);
		mreg_t rd;
		while (idling_on && $urandom_range(99) < IdlePct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		reg_addr   <= addr;
		write_data <= wdata;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		rd = phy_reg_access(op, addr, wdata);
		rd_data_q.push_back(typed ? typed_rd : rd);
	endtask

	task automatic send_random_access();
		logic   op;
		maddr_t addr;
		mreg_t  wdata;
		op    = ($urandom_range(99) < 45) ? OP_WRITE : OP_READ;
		addr  = ($urandom_range(99) < 40) ? maddr_t'($urandom_range(5))
		                                  : maddr_t'($urandom_range(31));
		wdata = mreg_t'($urandom());
		// keep soft resets rarer so the defaults do not mask everything
		if (addr == ADDR_CTRL && $urandom_range(3) != 0)
			wdata[CTRL_RESET_BIT] = 1'b0;
		send_access(op, addr, wdata, 1'b0, '0);
	endtask

	task automatic write_enable(input logic en);
		logic [31:0] v;
		v       = $urandom();
		v[0]    = en;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(4 * int'(CFG_IDX_ENABLE));
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		phy_en  = en;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (rd_data_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic en;
		for (int i = 0; i < NumRegs; i++)
			phy_regs[i] = '0;
		load_phy_defaults();
		phy_en = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DirTab[i]) begin
			if (DirTab[i].kind == ROW_CFG) begin
				drain();
				write_enable(DirTab[i].data[0]);
			end else begin
				send_access(DirTab[i].op, DirTab[i].addr, DirTab[i].data,
					DirTab[i].typed, DirTab[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			en = (ph == 3) ? 1'b0 : 1'b1;
			write_enable(en);
			idling_on = (ph != 5);
			repeat ((ph == 3) ? 60 : 260) begin
				if ($urandom_range(149) == 0)
					drain();
				send_random_access();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin : rd_check
		mreg_t want_rd;
		if (arst_n && done) begin
			if (rd_data_q.size() == 0) begin
				$error("read_data: no access outstanding, expected none, actual %h", read_data);
				n_errors++;
			end else begin
				want_rd = rd_data_q.pop_front();
				if (read_data !== want_rd) begin
					$error("read_data: expected %h, actual %h", want_rd, read_data);
					n_errors++;
				end
			end
		end
	end

	// cycles with neither an item taken nor a result shown
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == StallLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
